@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the servo turnout ramp sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked property, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, also checked during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ rtl/stsq_pkg.sv @@
// Types and constants of the servo turnout ramp sequencer.
`default_nettype none

package stsq_pkg;

  // Command carried in the input beat's tuser
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2
  } func_t;

  // Turnout position code
  typedef enum logic [1:0] {
    POS_PLUS         = 2'd0,
    POS_MINUS        = 2'd1,
    POS_MOVING_PLUS  = 2'd2,
    POS_MOVING_MINUS = 2'd3
  } pos_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_MOVE_STEP  = 2'd0;
  localparam logic [1:0] CFG_BEGIN_HOLD = 2'd1;
  localparam logic [1:0] CFG_END_HOLD   = 2'd2;

  // Configuration reset values
  localparam logic [9:0] MOVE_STEP_RST  = 10'd10;
  localparam logic [7:0] BEGIN_HOLD_RST = 8'd6;
  localparam logic [7:0] END_HOLD_RST   = 8'd25;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned CFG_DATA_W = 10;

  // Input item: tuser on top, then tdata laid out from its top bit down
  typedef struct packed {
    func_t              func;
    logic [7:0]         servo_channel;
    logic [14:0]        half_width;
    logic signed [15:0] start_angle;
    logic               target_side;
  } in_item_t;

  // Result item, lowest field last
  typedef struct packed {
    logic               done_res;
    pos_t               position;
    logic signed [15:0] out_angle;
    logic [7:0]         out_channel;
    logic               pwm_on;
    logic               busy_res;
  } res_t;

  typedef struct packed {
    logic [9:0] move_step;
    logic [7:0] begin_hold_ticks;
    logic [7:0] end_hold_ticks;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/stsq_in_stage.sv @@
// Input register stage of the servo turnout ramp sequencer.
`default_nettype none

module stsq_in_stage (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  input  wire logic [stsq_pkg::IN_DATA_W-1:0]         s_tdata,
  input  wire logic [stsq_pkg::IN_USER_W-1:0]         s_tuser,
  input  wire logic                                   advance,
  output logic                                        in_valid,
  output stsq_pkg::in_item_t                          item
);

  // Space when empty or when the held beat moves on this cycle
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= stsq_pkg::in_item_t'({s_tuser, s_tdata});
    end
  end

endmodule

`default_nettype wire

@@ rtl/stsq_core.sv @@
// Move state and per-item update of the servo turnout ramp sequencer.
`default_nettype none

module stsq_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire stsq_pkg::in_item_t item,
  input  wire stsq_pkg::cfg_t     cfg,
  output stsq_pkg::res_t          res
);

  logic               active, active_next;
  logic               target_minus, target_minus_next;
  logic [7:0]         channel_reg, channel_reg_next;
  logic signed [15:0] angle_reg, angle_reg_next;
  logic [14:0]        width_reg, width_reg_next;
  logic [7:0]         begin_count, begin_count_next;
  logic [7:0]         end_count, end_count_next;
  stsq_pkg::pos_t     position_reg, position_reg_next;
  logic               done;

  logic signed [16:0] angle_dn, angle_up;
  logic signed [15:0] angle_dn_sat, angle_up_sat;
  logic signed [15:0] width_pos, width_neg;
  logic               at_limit;
  logic [7:0]         end_inc;

  // Stepped angles with 16-bit saturation
  assign angle_dn = {angle_reg[15], angle_reg} - $signed({7'b0, cfg.move_step});
  assign angle_up = {angle_reg[15], angle_reg} + $signed({7'b0, cfg.move_step});
  assign angle_dn_sat = (angle_dn[16:15] == 2'b10) ? 16'sh8000 : angle_dn[15:0];
  assign angle_up_sat = (angle_up[16:15] == 2'b01) ? 16'sh7FFF : angle_up[15:0];

  // Travel limits
  assign width_pos = $signed({1'b0, width_reg});
  assign width_neg = -width_pos;
  assign at_limit  = target_minus ? (angle_reg >= width_pos) : (angle_reg <= width_neg);
  assign end_inc   = end_count + 8'd1;

  // Next state for one item
  always_comb begin
    active_next       = active;
    target_minus_next = target_minus;
    channel_reg_next  = channel_reg;
    angle_reg_next    = angle_reg;
    width_reg_next    = width_reg;
    begin_count_next  = begin_count;
    end_count_next    = end_count;
    position_reg_next = position_reg;
    done              = 1'b0;
    case (item.func)
      stsq_pkg::FUNC_START: begin
        target_minus_next = item.target_side;
        angle_reg_next    = item.start_angle;
        width_reg_next    = item.half_width;
        channel_reg_next  = item.servo_channel;
        begin_count_next  = 8'd0;
        end_count_next    = 8'd0;
        position_reg_next = item.target_side ? stsq_pkg::POS_MOVING_MINUS
                                             : stsq_pkg::POS_MOVING_PLUS;
        active_next       = 1'b1;
      end
      stsq_pkg::FUNC_STOP: begin
        if (active) begin
          active_next = 1'b0;
          done        = 1'b1;
        end
      end
      stsq_pkg::FUNC_TICK: begin
        if (active) begin
          if (begin_count < cfg.begin_hold_ticks) begin
            begin_count_next = begin_count + 8'd1;
          end else if (at_limit) begin
            end_count_next = end_inc;
            if (end_inc >= cfg.end_hold_ticks) begin
              position_reg_next = target_minus ? stsq_pkg::POS_MINUS : stsq_pkg::POS_PLUS;
              active_next       = 1'b0;
              done              = 1'b1;
            end
          end else begin
            angle_reg_next = target_minus ? angle_up_sat : angle_dn_sat;
          end
        end
      end
      default: begin
        // unused command code: the state is left unchanged
      end
    endcase
  end

  // Result of this item
  always_comb begin
    res.busy_res    = active_next;
    res.pwm_on      = active_next;
    res.out_channel = channel_reg_next;
    res.out_angle   = angle_reg_next;
    res.position    = position_reg_next;
    res.done_res    = done;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      target_minus <= 1'b0;
      channel_reg  <= 8'd0;
      angle_reg    <= 16'sd0;
      width_reg    <= 15'd0;
      begin_count  <= 8'd0;
      end_count    <= 8'd0;
      position_reg <= stsq_pkg::POS_PLUS;
    end else if (fire) begin
      active       <= active_next;
      target_minus <= target_minus_next;
      channel_reg  <= channel_reg_next;
      angle_reg    <= angle_reg_next;
      width_reg    <= width_reg_next;
      begin_count  <= begin_count_next;
      end_count    <= end_count_next;
      position_reg <= position_reg_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/servo_turnout_ramp_sequencer_top.sv @@
// Servo turnout ramp sequencer: top level with configuration and result register.
//
// Input stream s_*: one beat per command. s_tuser carries the command
// (tick, start, stop); s_tdata carries the start parameters. Output stream
// m_*: exactly one result beat per input beat, in order.
// Configuration: cfg_we/cfg_index/cfg_data write move step, begin hold and
// end hold; write only while no beat is in flight.
// Path: an accepted beat is held in the input register until the result
// register is free; the move update is combinational and is registered in
// the result register, from which the result is offered on m_*.
// Throughput: one beat per cycle while m_tready stays high; the move
// registers update once for each beat that advances to the result register.
// Stall: when m_tready is low the result register holds, the input register
// still takes one more beat, then s_tready drops until the result is taken.
// Reset: rst (synchronous) empties both registers, sets the turnout idle at
// the plus position with angle and channel zero, and restores the register
// defaults (step 10, begin hold 6, end hold 25).
`default_nettype none
`include "assert_macros.svh"

module servo_turnout_ramp_sequencer_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // target_side[0], start_angle[16:1], half_width[31:17], servo_channel[39:32]
  input  wire logic [stsq_pkg::IN_DATA_W-1:0]       s_tdata,
  // func[1:0]
  input  wire logic [stsq_pkg::IN_USER_W-1:0]       s_tuser,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // busy_res[0], pwm_on[1], out_channel[9:2], out_angle[25:10],
  // position[27:26], done_res[28], zero fill [31:29]
  output logic [stsq_pkg::OUT_DATA_W-1:0]           m_tdata,
  input  wire logic                                 cfg_we,
  input  wire logic [1:0]                           cfg_index,
  input  wire logic [stsq_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic               in_valid;
  logic               advance;
  stsq_pkg::in_item_t item;
  stsq_pkg::cfg_t     cfg;
  stsq_pkg::res_t     res;
  stsq_pkg::res_t     res_q;

  // Held beat moves on when the result register is free
  assign advance = in_valid && (!m_tvalid || m_tready);

  stsq_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .in_valid (in_valid),
    .item     (item)
  );

  stsq_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.move_step        <= stsq_pkg::MOVE_STEP_RST;
      cfg.begin_hold_ticks <= stsq_pkg::BEGIN_HOLD_RST;
      cfg.end_hold_ticks   <= stsq_pkg::END_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        stsq_pkg::CFG_MOVE_STEP:  cfg.move_step        <= cfg_data;
        stsq_pkg::CFG_BEGIN_HOLD: cfg.begin_hold_ticks <= cfg_data[7:0];
        stsq_pkg::CFG_END_HOLD:   cfg.end_hold_ticks   <= cfg_data[7:0];
        default: begin
          // no register at this index
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_tdata = {3'b000, res_q};

  // A finished or stopped move is never reported busy
  `ASSERT_CLK(a_done_not_busy, clk, rst, m_tvalid |-> !(res_q.done_res && res_q.busy_res), "done with busy")
  // A busy result always shows a moving position
  `ASSERT_CLK(a_busy_moving, clk, rst, (m_tvalid && res_q.busy_res) |-> res_q.position[1], "busy not moving")
  // Input only back-pressures when the result register is stalled
  `ASSERT_CLK(a_stall_cause, clk, rst, !s_tready |-> (m_tvalid && !m_tready), "stall without cause")
  // Both registers empty straight after a reset edge
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, rst |=> (!m_tvalid && s_tready), "not empty after reset")

endmodule

`default_nettype wire
